/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertions clocked on clk and switched off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sce_pkg.sv */
`default_nettype none

package sce_pkg;

    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_TIME_CONST = 1'd0;
    localparam cfg_idx_t REG_CENTER     = 1'd1;

    localparam int CFG_DATA_W = 12;
    localparam int TC_W       = 10;
    localparam int CENTER_W   = 12;
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int ANGLE_W    = 16;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE = 16'd35999;

    // Angles inside the core are in units of 2^-16 centidegree.
    localparam int TURN_W = 34;
    typedef logic signed [TURN_W-1:0] turn_t;
    localparam turn_t HALF_TURN = 34'sd1179648000;
    localparam turn_t FULL_TURN = 34'sd2359296000;

    localparam int TAB_LEN = 24;
    localparam int ATAN_W  = 30;
    typedef logic [ATAN_W-1:0] atan_t;

    function automatic atan_t atan_lookup(input logic [4:0] idx);
        atan_t v;
        case (idx)
            5'd0:    v = 30'd294912000;
            5'd1:    v = 30'd174096719;
            5'd2:    v = 30'd91987925;
            5'd3:    v = 30'd46694507;
            5'd4:    v = 30'd23437865;
            5'd5:    v = 30'd11730358;
            5'd6:    v = 30'd5866610;
            5'd7:    v = 30'd2933484;
            5'd8:    v = 30'd1466765;
            5'd9:    v = 30'd733385;
            5'd10:   v = 30'd366693;
            5'd11:   v = 30'd183347;
            5'd12:   v = 30'd91673;
            5'd13:   v = 30'd45837;
            5'd14:   v = 30'd22918;
            5'd15:   v = 30'd11459;
            5'd16:   v = 30'd5730;
            5'd17:   v = 30'd2865;
            5'd18:   v = 30'd1432;
            5'd19:   v = 30'd716;
            5'd20:   v = 30'd358;
            5'd21:   v = 30'd179;
            5'd22:   v = 30'd90;
            5'd23:   v = 30'd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/sincos_encoder_angle_core.sv */
// Channel    Direction  Handshake               Contents
// s_         in         s_tvalid / s_tready     cos_sample, sin_sample, timestamp_ms
// m_         out        m_tvalid / m_tready     angle_centideg (tdata), angle_valid (tuser)
// cfg_       in         cfg_we                  time_constant_ms, center_offset
//
// An angle is ready once the bit-serial filter division and the CORDIC rotation loop are through;
// the rotation ends early when its residue reaches zero, and a zero range skips it.
// The core takes a new sample only while its sequencer is idle, from the cycle after an angle
// is loaded, so it cannot take a new sample before it is through with the last one.
// A finished angle sits in the output register, so the next sample can enter while it waits;
// the following angle holds the sequencer until the waiting one is taken.
// rst_n is asynchronous and clears the filter, the min/max trackers and the handshakes.
`default_nettype none

module sincos_encoder_angle_core
    import sce_pkg::*;
#(
    parameter int ADC_BITS     = 12,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [11:0] cos_sample, [23:12] sin_sample, [55:24] timestamp_ms
    input  wire logic [55:0]           s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] angle_centideg
    output logic [ANGLE_W-1:0]         m_tdata,
    // [0] angle_valid
    output logic                       m_tuser,
    input  wire logic                  cfg_we,
    input  wire cfg_idx_t              cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FILT_W  = ADC_BITS + FRAC_BITS;
    localparam int CENT_W  = (ADC_BITS > 12 ? ADC_BITS : 12) + FRAC_BITS;
    localparam int DROP    = CENT_W > 30 ? CENT_W - 30 : 0;
    localparam int MAG_W   = CENT_W - DROP;
    localparam int ALPHA_W = FRAC_BITS + 1;
    localparam int OPA_W   = FILT_W > MAG_W ? FILT_W : MAG_W;
    localparam int OPB_W   = ALPHA_W > MAG_W ? ALPHA_W : MAG_W;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int XW      = 2 * MAG_W + 3;
    localparam int ZW      = 32;
    localparam int LIMIT   = CORDIC_STEPS < TAB_LEN ? CORDIC_STEPS : TAB_LEN;
    localparam int CNT_MAX = FRAC_BITS > TAB_LEN ? FRAC_BITS : TAB_LEN;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIVI   = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_MINMAX = 4'd4;
    localparam logic [3:0] ST_CENTER = 4'd5;
    localparam logic [3:0] ST_MULXY  = 4'd6;
    localparam logic [3:0] ST_CORDIC = 4'd7;
    localparam logic [3:0] ST_FINAL  = 4'd8;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_BITS;

    logic [3:0]            state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [TC_W-1:0]       tc_reg;
    logic [CENTER_W-1:0]   center_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic [ADC_BITS-1:0]   raw_c_reg;
    logic [ADC_BITS-1:0]   raw_s_reg;
    logic [TIME_W:0]       den_reg;
    logic [TIME_W+1:0]     rem_reg;
    logic [ALPHA_W-1:0]    q_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [FILT_W-1:0]     acc_reg;
    logic [FILT_W-1:0]     filt_c_reg;
    logic [FILT_W-1:0]     filt_s_reg;
    logic [FILT_W-1:0]     low_c_reg;
    logic [FILT_W-1:0]     high_c_reg;
    logic [FILT_W-1:0]     low_s_reg;
    logic [FILT_W-1:0]     high_s_reg;
    logic                  neg_c_reg;
    logic                  neg_s_reg;
    logic                  ok_reg;
    logic [MAG_W-1:0]      mag_c_reg;
    logic [MAG_W-1:0]      mag_s_reg;
    logic [MAG_W-1:0]      rcd_reg;
    logic [MAG_W-1:0]      rsd_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic                  m_tvalid_reg;
    logic [ANGLE_W-1:0]    angle_reg;
    logic                  flag_reg;

    logic [TIME_W-1:0]     h;
    logic [ALPHA_W-1:0]    one_minus;
    logic [OPA_W-1:0]      opa;
    logic [OPB_W-1:0]      opb;
    logic [PROD_W-1:0]     prod_next;
    logic [FILT_W:0]       filt_sum;
    logic [TIME_W+1:0]     rem2;
    logic [FILT_W-1:0]     rc;
    logic [FILT_W-1:0]     rs;
    logic [CENT_W-1:0]     center_ext;
    logic [CENT_W-1:0]     fc_ext;
    logic [CENT_W-1:0]     fs_ext;
    logic signed [XW-1:0]  sx;
    logic signed [XW-1:0]  sy;
    logic signed [ZW-1:0]  atan_val;
    turn_t                 z_ext;
    turn_t                 full_q;
    turn_t                 full_w;
    logic [TURN_W-1:0]     rounded;
    logic [TURN_W-17:0]    angle_raw;
    logic [ANGLE_W-1:0]    angle_fin;
    logic                  out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = angle_reg;
    assign m_tuser  = flag_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign h         = s_tdata[55:24] - last_time_reg;
    assign one_minus = ALPHA_ONE - q_reg;
    assign rem2      = {rem_reg[TIME_W:0], 1'b0};

    // Operand select for the shared multiplier.
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (state_reg)
            ST_MUL:
            begin
                case (cnt_reg)
                    CNT_W'(0):
                    begin
                        opa = OPA_W'(raw_c_reg);
                        opb = OPB_W'(q_reg);
                    end
                    CNT_W'(1):
                    begin
                        opa = OPA_W'(filt_c_reg);
                        opb = OPB_W'(one_minus);
                    end
                    CNT_W'(2):
                    begin
                        opa = OPA_W'(raw_s_reg);
                        opb = OPB_W'(q_reg);
                    end
                    CNT_W'(3):
                    begin
                        opa = OPA_W'(filt_s_reg);
                        opb = OPB_W'(one_minus);
                    end
                    default:
                    begin
                        opa = '0;
                        opb = '0;
                    end
                endcase
            end
            ST_MULXY:
            begin
                if (cnt_reg == CNT_W'(0))
                begin
                    opa = OPA_W'(mag_c_reg);
                    opb = OPB_W'(rsd_reg);
                end
                else
                begin
                    opa = OPA_W'(mag_s_reg);
                    opb = OPB_W'(rcd_reg);
                end
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(opa) * PROD_W'(opb);
    assign filt_sum  = (FILT_W + 1)'(acc_reg) + (FILT_W + 1)'(prod_reg >> FRAC_BITS);

    assign rc = (high_c_reg > low_c_reg) ? high_c_reg - low_c_reg : '0;
    assign rs = (high_s_reg > low_s_reg) ? high_s_reg - low_s_reg : '0;
    assign center_ext = CENT_W'({center_reg, {FRAC_BITS{1'b0}}});
    assign fc_ext     = CENT_W'(filt_c_reg);
    assign fs_ext     = CENT_W'(filt_s_reg);

    assign sx       = x_reg >>> cnt_reg;
    assign sy       = y_reg >>> cnt_reg;
    assign atan_val = ZW'($signed({2'b00, atan_lookup(5'(cnt_reg))}));

    // Unfold the first-quadrant angle by the signs of the centred channels.
    always_comb
    begin
        z_ext = TURN_W'(z_reg);
        if (!neg_c_reg && !neg_s_reg)
            full_q = z_ext;
        else if (neg_c_reg && !neg_s_reg)
            full_q = HALF_TURN - z_ext;
        else if (neg_c_reg && neg_s_reg)
            full_q = HALF_TURN + z_ext;
        else
            full_q = FULL_TURN - z_ext;
        full_w = full_q;
        if (full_q < 0)
            full_w = full_q + FULL_TURN;
        else if (full_q >= FULL_TURN)
            full_w = full_q - FULL_TURN;
    end

    assign rounded   = TURN_W'(full_w) + TURN_W'(32768);
    assign angle_raw = rounded[TURN_W-1:16];
    assign angle_fin = (angle_raw >= (TURN_W - 16)'(36000))
                     ? ANGLE_W'(angle_raw - (TURN_W - 16)'(36000))
                     : ANGLE_W'(angle_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg     <= TC_W'(50);
            center_reg <= CENTER_W'(2059);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIME_CONST: tc_reg     <= cfg_data[TC_W-1:0];
                REG_CENTER:     center_reg <= cfg_data[CENTER_W-1:0];
                default:        tc_reg     <= tc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_time_reg <= '0;
            filt_c_reg    <= '0;
            filt_s_reg    <= '0;
            low_c_reg     <= '1;
            low_s_reg     <= '1;
            high_c_reg    <= '0;
            high_s_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            // In ST_FINAL the valid flag is handled by the sequencer below.
            if (m_tvalid_reg && m_tready && state_reg != ST_FINAL)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        last_time_reg <= s_tdata[55:24];
                        raw_c_reg     <= ADC_BITS'(s_tdata[11:0]);
                        raw_s_reg     <= ADC_BITS'(s_tdata[23:12]);
                        den_reg       <= (TIME_W + 1)'(h) + (TIME_W + 1)'(tc_reg);
                        rem_reg       <= (TIME_W + 2)'(h);
                        state_reg     <= ST_DIVI;
                    end
                end
                ST_DIVI:
                begin
                    cnt_reg <= '0;
                    if (den_reg == '0)
                    begin
                        // No time passed and a zero time constant: take the raw sample.
                        q_reg     <= ALPHA_ONE;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        if (rem_reg >= (TIME_W + 2)'(den_reg))
                        begin
                            rem_reg <= rem_reg - (TIME_W + 2)'(den_reg);
                            q_reg   <= ALPHA_W'(1);
                        end
                        else
                        begin
                            q_reg   <= '0;
                        end
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (rem2 >= (TIME_W + 2)'(den_reg))
                    begin
                        rem_reg <= rem2 - (TIME_W + 2)'(den_reg);
                        q_reg   <= {q_reg[ALPHA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem2;
                        q_reg   <= {q_reg[ALPHA_W-2:0], 1'b0};
                    end
                    if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_MUL:
                begin
                    // Products are registered, so each comes out in the cycle after its operands go in.
                    prod_reg <= prod_next;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    case (cnt_reg)
                        CNT_W'(1): acc_reg    <= FILT_W'(prod_reg);
                        CNT_W'(2): filt_c_reg <= filt_sum[FILT_W-1:0];
                        CNT_W'(3): acc_reg    <= FILT_W'(prod_reg);
                        CNT_W'(4):
                        begin
                            filt_s_reg <= filt_sum[FILT_W-1:0];
                            state_reg  <= ST_MINMAX;
                        end
                        default:   acc_reg    <= acc_reg;
                    endcase
                end
                ST_MINMAX:
                begin
                    if (filt_c_reg < low_c_reg)
                        low_c_reg <= filt_c_reg;
                    if (filt_c_reg > high_c_reg)
                        high_c_reg <= filt_c_reg;
                    if (filt_s_reg < low_s_reg)
                        low_s_reg <= filt_s_reg;
                    if (filt_s_reg > high_s_reg)
                        high_s_reg <= filt_s_reg;
                    state_reg <= ST_CENTER;
                end
                ST_CENTER:
                begin
                    cnt_reg   <= '0;
                    neg_c_reg <= fc_ext < center_ext;
                    neg_s_reg <= fs_ext < center_ext;
                    mag_c_reg <= MAG_W'(((fc_ext < center_ext) ? center_ext - fc_ext
                                                               : fc_ext - center_ext) >> DROP);
                    mag_s_reg <= MAG_W'(((fs_ext < center_ext) ? center_ext - fs_ext
                                                               : fs_ext - center_ext) >> DROP);
                    rcd_reg   <= MAG_W'(rc >> DROP);
                    rsd_reg   <= MAG_W'(rs >> DROP);
                    if (rc == '0 || rs == '0)
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        ok_reg    <= 1'b1;
                        state_reg <= ST_MULXY;
                    end
                end
                ST_MULXY:
                begin
                    prod_reg <= prod_next;
                    if (cnt_reg == CNT_W'(0))
                    begin
                        cnt_reg <= CNT_W'(1);
                    end
                    else if (cnt_reg == CNT_W'(1))
                    begin
                        x_reg   <= XW'(prod_reg);
                        cnt_reg <= CNT_W'(2);
                    end
                    else
                    begin
                        y_reg     <= XW'(prod_reg);
                        z_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_CORDIC;
                    end
                end
                ST_CORDIC:
                begin
                    if (cnt_reg == CNT_W'(LIMIT) || y_reg == '0)
                    begin
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        if (y_reg > 0)
                        begin
                            x_reg <= x_reg + sy;
                            y_reg <= y_reg - sx;
                            z_reg <= z_reg + atan_val;
                        end
                        else
                        begin
                            x_reg <= x_reg - sy;
                            y_reg <= y_reg + sx;
                            z_reg <= z_reg - atan_val;
                        end
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        angle_reg    <= ok_reg ? angle_fin : '0;
                        flag_reg     <= ok_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/sce_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module sce_checker
    import sce_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [ANGLE_W-1:0] m_tdata,
    input wire logic               m_tuser
);

    `ASSERT_IMPL(a_angle_range, m_tvalid, m_tdata <= MAX_ANGLE, "angle beyond one turn")
    `ASSERT_IMPL(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == '0, "invalid angle not zero")
    `ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready after sample taken")
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind sincos_encoder_angle_core sce_checker u_sce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
    import sce_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam logic [27:0] FILT_ONES = 28'hFFFFFFF;

    typedef struct packed {
        logic [15:0] angle;
        logic        valid;
    } angle_res_t;

    // Holds the tracker state of the encoder front end and the queue of
    // angles that the core still owes.
    class angle_scoreboard;
        logic [9:0]  tc;
        logic [11:0] center;
        logic [31:0] last_t;
        logic [27:0] f_c, f_s, c_lo, c_hi, s_lo, s_hi;
        angle_res_t  pending[$];
        int          errors;
        int          checked;
        int          invalid_seen;

        function void clear_state();
            tc = 10'd50;
            center = 12'd2059;
            last_t = '0;
            f_c = '0;
            f_s = '0;
            c_lo = FILT_ONES;
            s_lo = FILT_ONES;
            c_hi = '0;
            s_hi = '0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [11:0] val);
            if (idx == REG_TIME_CONST)
                tc = val[9:0];
            else if (idx == REG_CENTER)
                center = val;
        endfunction

        function longint floor_shift(longint v, int n);
            if (v < 0)
                return -((~v) >>> n) - 1;
            return v >>> n;
        endfunction

        function logic [27:0] smooth(logic [11:0] raw, logic [27:0] prev, longint alpha);
            longint keep;
            keep = (longint'(prev) * (65536 - alpha)) >> FRAC;
            return 28'(longint'(raw) * alpha + keep);
        endfunction

        function longint rotate(longint x, longint y);
            longint z, nx;
            z = 0;
            for (int i = 0; i < 16; i++)
            begin
                if (y == 0)
                    break;
                if (y > 0)
                begin
                    nx = x + floor_shift(y, i);
                    y = y - floor_shift(x, i);
                    z += longint'(atan_tab(i));
                end
                else
                begin
                    nx = x - floor_shift(y, i);
                    y = y + floor_shift(x, i);
                    z -= longint'(atan_tab(i));
                end
                x = nx;
            end
            return z;
        endfunction

        function longint atan_tab(int i);
            longint t[16] = '{294912000, 174096719, 91987925, 46694507, 23437865,
                              11730358, 5866610, 2933484, 1466765, 733385, 366693,
                              183347, 91673, 45837, 22918, 11459};
            return t[i];
        endfunction

        function void note_sample(logic [11:0] rc, logic [11:0] rs, logic [31:0] ts);
            longint h, den, alpha, rng_c, rng_s, cen, mc, ms, th, full;
            logic [31:0] dt;
            bit nc, ns;
            angle_res_t r;
            // The elapsed time wraps at 32 bits.
            dt = ts - last_t;
            h = longint'(dt);
            den = h + tc;
            alpha = (den != 0) ? (h << FRAC) / den : 65536;
            last_t = ts;
            f_c = smooth(rc, f_c, alpha);
            f_s = smooth(rs, f_s, alpha);
            if (f_c < c_lo) c_lo = f_c;
            if (f_c > c_hi) c_hi = f_c;
            if (f_s < s_lo) s_lo = f_s;
            if (f_s > s_hi) s_hi = f_s;
            rng_c = (c_hi > c_lo) ? longint'(c_hi) - longint'(c_lo) : 0;
            rng_s = (s_hi > s_lo) ? longint'(s_hi) - longint'(s_lo) : 0;
            if (rng_c == 0 || rng_s == 0)
            begin
                r.angle = '0;
                r.valid = 1'b0;
            end
            else
            begin
                cen = longint'(center) << FRAC;
                nc = longint'(f_c) < cen;
                ns = longint'(f_s) < cen;
                mc = nc ? cen - f_c : f_c - cen;
                ms = ns ? cen - f_s : f_s - cen;
                th = rotate(mc * rng_s, ms * rng_c);
                if (!nc && !ns)
                    full = th;
                else if (nc && !ns)
                    full = 64'd1179648000 - th;
                else if (nc && ns)
                    full = 64'd1179648000 + th;
                else
                    full = 64'd2359296000 - th;
                if (full < 0) full += 64'd2359296000;
                if (full >= 64'd2359296000) full -= 64'd2359296000;
                full = (full + 32768) >>> 16;
                if (full >= 36000) full -= 36000;
                r.angle = 16'(full);
                r.valid = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void check_angle(logic [15:0] ang, logic vld);
            angle_res_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected angle %0d valid %0d", ang, vld);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (!vld) invalid_seen++;
            if (ang !== e.angle)
            begin
                $error("angle_centideg expected %0d actual %0d", e.angle, ang);
                errors++;
            end
            if (vld !== e.valid)
            begin
                $error("angle_valid expected %0d actual %0d", e.valid, vld);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [11:0] cfg_data;

    angle_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    logic [31:0] now_ms;

    sincos_encoder_angle_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold-off when asked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_angle(m_tdata, m_tuser);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // tvalid stays high after a transaction until the next sample or an idle cycle replaces it.
    task automatic send_sample(logic [11:0] c, logic [11:0] s, logic [31:0] ts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ts, s, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(c, s, ts);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Mostly a rotating shaft with noise and random time steps; sometimes junk.
    task automatic random_run(int n);
        real ph, amp;
        int c, s;
        amp = $urandom_range(1900, 50);
        ph = $urandom_range(359);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                c = $urandom_range(4095);
                s = $urandom_range(4095);
            end
            else
            begin
                ph += $urandom_range(40);
                c = 2048 + int'(amp * $cos(ph * 3.14159 / 180.0)) + $urandom_range(8) - 4;
                s = 2048 + int'(amp * $sin(ph * 3.14159 / 180.0)) + $urandom_range(8) - 4;
                if (c < 0) c = 0;
                if (c > 4095) c = 4095;
                if (s < 0) s = 0;
                if (s > 4095) s = 4095;
            end
            case ($urandom_range(9))
                0: now_ms = $urandom;
                1: now_ms = now_ms;
                2: now_ms = now_ms + $urandom_range(5000);
                default: now_ms = now_ms + $urandom_range(20, 1);
            endcase
            send_sample(12'(c), 12'(s), now_ms);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TIME_CONST;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        now_ms = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the first sample sees no range, then extremes and corners.
        send_sample(12'd0, 12'd0, 32'd0);
        send_sample(12'd4095, 12'd4095, 32'd0);
        send_sample(12'd4095, 12'd0, 32'd10);
        send_sample(12'd0, 12'd4095, 32'd20);
        send_sample(12'd4095, 12'd4095, 32'hFFFFFFFF);
        send_sample(12'd0, 12'd0, 32'd5);
        send_sample(12'd2059, 12'd2059, 32'd1000);
        drain();
        write_reg(REG_TIME_CONST, 12'd0);
        write_reg(REG_CENTER, 12'd0);
        send_sample(12'd100, 12'd3000, 32'd1000);
        send_sample(12'd4000, 12'd50, 32'd1001);
        send_sample(12'd2048, 12'd2048, 32'd1001);
        drain();
        write_reg(REG_CENTER, 12'd4095);
        send_sample(12'd4095, 12'd0, 32'd2000);
        send_sample(12'd0, 12'd4095, 32'd2001);
        send_sample(12'hAAA, 12'h555, 32'hAAAAAAAA);
        send_sample(12'h555, 12'hAAA, 32'h55555555);
        drain();
        write_reg(REG_TIME_CONST, 12'd1023);
        write_reg(REG_CENTER, 12'd2048);
        send_sample(12'd4095, 12'd0, 32'd3000);
        send_sample(12'd0, 12'd4095, 32'd4000000);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            drain();
            write_reg(REG_TIME_CONST, (ph == 3) ? 12'd1 : (ph == 6) ? 12'd1023
                                                 : 12'($urandom_range(200, 1)));
            write_reg(REG_CENTER, (ph == 5) ? 12'd0 : (ph == 7) ? 12'd4095
                                            : 12'($urandom_range(2200, 1900)));
            if (ph == 2)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_run(80);
        end

        drain();
        $display("Checked %0d angles, %0d of them flagged invalid, over several register settings",
                 sb.checked, sb.invalid_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

/* sincos_encoder_angle_core.f */
+incdir+rtl
rtl/sce_pkg.sv
rtl/sincos_encoder_angle_core.sv
rtl/sce_checker.sv
tb/sv/tb.sv
